// ----- hw/rtl/mhpq_pkg.sv -----
// Types and codes shared by the max-heap priority queue.
// Holds the request and response item structs, the heap entry format and the sequencer states.
// No dependencies.
package mhpq_pkg;

	// Request type codes. The unused code is served as a look at the maximum.
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_LOOK   = 2'd2;

	// Response status codes.
	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_ENTRY    = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam int OCC_W = 7;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [15:0] priority_req;
		logic [31:0]        payload;
	} heap_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [15:0] max_priority;
		logic [31:0]        max_payload;
		logic [OCC_W-1:0]   occupancy;
	} heap_rsp_t;

	// One stored entry: priority above payload, 48 bits in all.
	typedef struct packed {
		logic signed [15:0] prio;
		logic [31:0]        val;
	} heap_entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS,
		S_SIFT_LD,
		S_SIFT_GET,
		S_SIFT_L,
		S_SIFT_R,
		S_SIFT_CMP,
		S_SIFT_PUT,
		S_DEL_RD0,
		S_DEL_RDL,
		S_DEL_LD,
		S_LOOK_RD,
		S_LOOK_GET,
		S_DONE
	} heap_state_t;

endpackage

// ----- hw/rtl/max_heap_priority_queue.sv -----
// Binary max-heap priority queue with a two-port entry memory and a sift-down sequencer.
// Depends on mhpq_pkg for the item structs, the entry format, the codes and the states.
//
//   Channel | Direction | Handshake             | Item
//   req     | in        | req_valid / req_ready | heap_req_t
//   rsp     | out       | rsp_valid / rsp_ready | heap_rsp_t
//
// One request is worked at a time; req_ready is high only while the sequencer is idle.
// Look reads the root. Delete takes the root and sifts the last entry down from the root;
// insert writes the new entry at the end and sifts down every node from half the old
// count back to the root; each sift level reads both children, then compares.
// Reset clears the entry count and the handshake state; the entry memory needs no clearing.
// A stalled response holds in its register while the next request is already taken in.
module max_heap_priority_queue #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  mhpq_pkg::heap_req_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output mhpq_pkg::heap_rsp_t rsp
);
	import mhpq_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = AW + 2;

	heap_state_t state_q, state_d;

	heap_entry_t mem [CAPACITY];
	heap_entry_t rd_data_q;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	heap_entry_t   wr_data;

	heap_req_t   req_q;
	heap_entry_t cur_q, left_q, res_q;
	logic [1:0]  status_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] node_q, k_q;
	logic          rebuild_q;
	logic          rsp_valid_q;
	heap_rsp_t     rsp_q;

	logic          accept, full, empty, rsp_free;
	logic [LW-1:0] left_idx, right_idx, count_ext;
	logic          has_left, has_right, right_better, stop;
	heap_entry_t   child_e;
	logic [AW-1:0] child_idx;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign full      = (count_q >= CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Child positions of the current node and the choice between them.
	assign left_idx     = {1'b0, node_q, 1'b1};
	assign right_idx    = left_idx + LW'(1);
	assign count_ext    = LW'(count_q);
	assign has_left     = (left_idx < count_ext);
	assign has_right    = (right_idx < count_ext);
	assign right_better = has_right && (rd_data_q.prio > left_q.prio);
	assign child_e      = right_better ? rd_data_q : left_q;
	assign child_idx    = right_better ? AW'(right_idx) : AW'(left_idx);
	assign stop         = (cur_q.prio >= child_e.prio);

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.req_type)
						REQ_INSERT: state_d = full ? S_DONE : S_INS;
						REQ_DELETE: state_d = empty ? S_DONE : S_DEL_RD0;
						default:    state_d = empty ? S_DONE : S_LOOK_RD;
					endcase
				end
			end
			S_INS:      state_d = S_SIFT_LD;
			S_SIFT_LD:  state_d = S_SIFT_GET;
			S_SIFT_GET: state_d = S_SIFT_L;
			S_SIFT_L:   state_d = has_left ? S_SIFT_R : S_SIFT_PUT;
			S_SIFT_R:   state_d = S_SIFT_CMP;
			S_SIFT_CMP: state_d = stop ? S_SIFT_PUT : S_SIFT_L;
			S_SIFT_PUT: state_d = (rebuild_q && k_q != '0) ? S_SIFT_LD : S_DONE;
			S_DEL_RD0:  state_d = S_DEL_RDL;
			S_DEL_RDL:  state_d = S_DEL_LD;
			S_DEL_LD:   state_d = S_SIFT_L;
			S_LOOK_RD:  state_d = S_LOOK_GET;
			S_LOOK_GET: state_d = S_DONE;
			S_DONE:     state_d = rsp_free ? S_IDLE : S_DONE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Memory read and write controls for each state.
	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_data = cur_q;
		case (state_q)
			S_INS: begin
				wr_en   = 1'b1;
				wr_addr = AW'(count_q);
				wr_data = '{prio: req_q.priority_req, val: req_q.payload};
			end
			S_SIFT_LD: rd_addr = k_q;
			S_SIFT_L:  rd_addr = AW'(left_idx);
			S_SIFT_R:  rd_addr = AW'(right_idx);
			S_SIFT_CMP: begin
				wr_en   = !stop;
				wr_data = child_e;
			end
			S_SIFT_PUT: wr_en = 1'b1;
			S_DEL_RDL:  rd_addr = AW'(count_q - CW'(1));
			default:    rd_addr = '0;
		endcase
	end

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Entry count and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_INS) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == S_DEL_LD) begin
				count_q <= count_q - CW'(1);
			end
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the sift-down loop and the pending result.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q     <= req;
					rebuild_q <= 1'b0;
					res_q     <= '0;
					case (req.req_type)
						REQ_INSERT: status_q <= full ? ST_FULL : ST_INSERTED;
						default:    status_q <= empty ? ST_EMPTY : ST_ENTRY;
					endcase
				end
			end
			S_INS: begin
				k_q       <= AW'(count_q >> 1);
				rebuild_q <= 1'b1;
			end
			S_SIFT_LD:  node_q <= k_q;
			S_SIFT_GET: cur_q  <= rd_data_q;
			S_SIFT_R:   left_q <= rd_data_q;
			S_SIFT_CMP: begin
				if (!stop) begin
					node_q <= child_idx;
				end
			end
			S_SIFT_PUT: begin
				if (rebuild_q && k_q != '0) begin
					k_q <= k_q - AW'(1);
				end
			end
			S_DEL_RDL: res_q <= rd_data_q;
			S_DEL_LD: begin
				cur_q  <= rd_data_q;
				node_q <= '0;
			end
			S_LOOK_GET: res_q <= rd_data_q;
			S_DONE: begin
				if (rsp_free) begin
					rsp_q <= '{status: status_q, max_priority: res_q.prio,
						max_payload: res_q.val, occupancy: OCC_W'(count_q)};
				end
			end
			default: ;
		endcase
	end

	// The entry count never passes the capacity.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// An accepted request always starts the sequencer.
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> state_q != S_IDLE)
		else $error("request accepted without leaving idle");

	// A compare step only happens on a node that holds an entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SIFT_CMP |-> LW'(node_q) < count_ext)
		else $error("sift compare beyond the heap");

	// Responses without a returned entry carry zero priority and payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_ENTRY |-> rsp.max_priority == '0 && rsp.max_payload == '0)
		else $error("nonzero data on a response without an entry");

	// An insert that was not dropped leaves at least one entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS |=> count_q != '0)
		else $error("insert left the heap empty");

endmodule
